// ===== hw/rtl/grwc_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grwc_pkg
// types, status codes and the arctangent table shared by the ray caster
// ---------------------------------------------------------------------------
package grwc_pkg;

	// pass status codes
	localparam logic [1:0] ST_HIT   = 2'd0;
	localparam logic [1:0] ST_OFF   = 2'd1;
	localparam logic [1:0] ST_LIMIT = 2'd2;
	localparam logic [1:0] ST_PAR   = 2'd3;

	// configuration register indexes
	localparam logic REG_MAP_COLS = 1'b0;
	localparam logic REG_MAP_ROWS = 1'b1;

	// reset values of the configuration registers
	localparam logic [5:0] MAP_COLS_RST = 6'd18;
	localparam logic [5:0] MAP_ROWS_RST = 6'd7;

	// pi/2 in q30 radians
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

	// number of rotation iterations
	localparam int ROT_ITERS = 30;

	// quotient bits of the slope divide: 31-bit magnitude shifted by 16
	localparam int DIV_BITS = 47;

	// slope magnitude clamp, large enough that any clamped slope leaves the map
	localparam logic [36:0] RATIO_CLAMP = 37'h1F_FFFF_FFFF;

	// command from controller to datapath
	typedef struct packed {
		logic clr;
		logic wr;
		logic load;
		logic rot;
		logic quad;
		logic div;
		logic pset;
		logic pmul;
		logic look;
		logic check;
		logic last;
		logic pass;
		logic emit;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic par;
		logic fin;
	} sts_t;

	// arctangent of 2^-i in q30 radians
	function automatic logic [31:0] atan_q30(input logic [4:0] i);
		logic [31:0] v;
		case (i)
			5'd0:    v = 32'h3243F6A8;
			5'd1:    v = 32'h1DAC6705;
			5'd2:    v = 32'h0FADBAFC;
			5'd3:    v = 32'h07F56EA6;
			5'd4:    v = 32'h03FEAB76;
			5'd5:    v = 32'h01FFD55B;
			5'd6:    v = 32'h00FFFAAA;
			5'd7:    v = 32'h007FFF55;
			5'd8:    v = 32'h003FFFEA;
			5'd9:    v = 32'h001FFFFD;
			5'd10:   v = 32'h000FFFFF;
			5'd11:   v = 32'h0007FFFF;
			5'd12:   v = 32'h0003FFFF;
			5'd13:   v = 32'h0001FFFF;
			5'd14:   v = 32'h0000FFFF;
			5'd15:   v = 32'h00007FFF;
			5'd16:   v = 32'h00003FFF;
			5'd17:   v = 32'h00001FFF;
			5'd18:   v = 32'h00000FFF;
			5'd19:   v = 32'h000007FF;
			5'd20:   v = 32'h000003FF;
			5'd21:   v = 32'h000001FF;
			5'd22:   v = 32'h000000FF;
			5'd23:   v = 32'h0000007F;
			5'd24:   v = 32'h0000003F;
			5'd25:   v = 32'h0000001F;
			5'd26:   v = 32'h0000000F;
			5'd27:   v = 32'h00000007;
			5'd28:   v = 32'h00000003;
			5'd29:   v = 32'h00000001;
			default: v = 32'h00000000;
		endcase
		return v;
	endfunction

endpackage

// ===== hw/rtl/grwc_ctrl.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grwc_ctrl
// sequencer: map clear, rotation, slope divide and the two grid passes
// ---------------------------------------------------------------------------
module grwc_ctrl #(
	parameter int CW        = 10,
	parameter int DEPTH     = 1024,
	parameter int MAX_STEPS = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  logic            op,
	output logic            out_valid,
	input  logic            out_ready,
	input  grwc_pkg::sts_t  sts,
	output grwc_pkg::cmd_t  cmd,
	output logic [CW-1:0]   idx
);

	typedef enum logic [9:0] {
		S_CLEAR = 10'b0000000001,
		S_IDLE  = 10'b0000000010,
		S_ROT   = 10'b0000000100,
		S_QUAD  = 10'b0000001000,
		S_DIV   = 10'b0000010000,
		S_PSET  = 10'b0000100000,
		S_PMUL  = 10'b0001000000,
		S_LOOK  = 10'b0010000000,
		S_CHECK = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	localparam logic [CW-1:0] CLR_LAST  = CW'(DEPTH - 1);
	localparam logic [CW-1:0] ROT_LAST  = CW'(grwc_pkg::ROT_ITERS - 1);
	localparam logic [CW-1:0] DIV_LAST  = CW'(grwc_pkg::DIV_BITS - 1);
	localparam logic [CW-1:0] STEP_LAST = CW'(MAX_STEPS - 1);

	state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d;
	logic pass_q, pass_d;
	logic out_valid_q, out_valid_d;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q;
		pass_d = pass_q;
		in_ready = 1'b0;
		cmd = '0;
		cmd.pass = pass_q;
		cmd.last = (cnt_q == STEP_LAST);
		unique case (state_q)
			S_CLEAR: begin
				cmd.clr = 1'b1;
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == CLR_LAST) begin
					cnt_d = '0;
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (op) begin
						cmd.load = 1'b1;
						cnt_d = '0;
						state_d = S_ROT;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			S_ROT: begin
				cmd.rot = 1'b1;
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == ROT_LAST) begin
					state_d = S_QUAD;
				end
			end
			S_QUAD: begin
				cmd.quad = 1'b1;
				cnt_d = '0;
				state_d = S_DIV;
			end
			S_DIV: begin
				cmd.div = 1'b1;
				cnt_d = cnt_q + CW'(1);
				if (cnt_q == DIV_LAST) begin
					cnt_d = '0;
					pass_d = 1'b0;
					state_d = S_PSET;
				end
			end
			S_PSET: begin
				cmd.pset = 1'b1;
				if (sts.par) begin
					if (pass_q) begin
						state_d = S_DONE;
					end else begin
						pass_d = 1'b1;
					end
				end else begin
					state_d = S_PMUL;
				end
			end
			S_PMUL: begin
				cmd.pmul = 1'b1;
				cnt_d = '0;
				state_d = S_LOOK;
			end
			S_LOOK: begin
				cmd.look = 1'b1;
				state_d = S_CHECK;
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (sts.fin) begin
					if (pass_q) begin
						state_d = S_DONE;
					end else begin
						pass_d = 1'b1;
						state_d = S_PSET;
					end
				end else begin
					cnt_d = cnt_q + CW'(1);
					state_d = S_LOOK;
				end
			end
			S_DONE: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_CLEAR;
			end
		endcase
	end

	always_comb begin
		out_valid_d = out_valid_q;
		if (cmd.emit) begin
			out_valid_d = 1'b1;
		end else if (out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			cnt_q <= '0;
			pass_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			pass_q <= pass_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid = out_valid_q;
	assign idx = cnt_q;

endmodule

// ===== hw/rtl/grwc_dp.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grwc_dp
// datapath: wall map, rotation unit, slope dividers and grid stepper
// ---------------------------------------------------------------------------
module grwc_dp #(
	parameter int CW           = 10,
	parameter int MAP_COLS_MAX = 32,
	parameter int MAP_ROWS_MAX = 32,
	parameter int ANGLE_STEPS  = 4096
) (
	input  logic                clk,
	input  logic                arst_n,
	input  grwc_pkg::cmd_t      cmd,
	input  logic [CW-1:0]       idx,
	output grwc_pkg::sts_t      sts,
	input  logic                cfg_valid,
	input  logic                cfg_index,
	input  logic [5:0]          cfg_data,
	input  logic [4:0]          cell_col,
	input  logic [4:0]          cell_row,
	input  logic                wall_bit,
	input  logic [18:0]         pos_x,
	input  logic [18:0]         pos_y,
	input  logic [11:0]         angle,
	output logic signed [23:0]  horiz_x,
	output logic signed [23:0]  horiz_y,
	output logic [1:0]          horiz_status,
	output logic signed [23:0]  vert_x,
	output logic signed [23:0]  vert_y,
	output logic [1:0]          vert_status
);

	localparam int DEPTH = MAP_ROWS_MAX * MAP_COLS_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int AAW   = $clog2(ANGLE_STEPS);
	localparam int CNW   = $clog2(MAP_COLS_MAX + 1);
	localparam int RNW   = $clog2(MAP_ROWS_MAX + 1);
	localparam int DB    = grwc_pkg::DIV_BITS;

	function automatic logic [30:0] mag31(input logic signed [31:0] v);
		logic [31:0] n;
		n = 32'(-v);
		return v[31] ? n[30:0] : v[30:0];
	endfunction

	function automatic logic [23:0] sat24(input logic signed [39:0] v);
		logic [23:0] r;
		if (v > 40'sd8388607) begin
			r = 24'h7FFFFF;
		end else if (v < -40'sd8388608) begin
			r = 24'h800000;
		end else begin
			r = v[23:0];
		end
		return r;
	endfunction

	// configuration
	logic [5:0] map_cols_q, map_rows_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_cols_q <= grwc_pkg::MAP_COLS_RST;
			map_rows_q <= grwc_pkg::MAP_ROWS_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				grwc_pkg::REG_MAP_COLS: map_cols_q <= cfg_data;
				grwc_pkg::REG_MAP_ROWS: map_rows_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CNW-1:0] cols_lim;
	logic [RNW-1:0] rows_lim;
	assign cols_lim = (32'(map_cols_q) > MAP_COLS_MAX) ? CNW'(MAP_COLS_MAX)
		: CNW'(map_cols_q);
	assign rows_lim = (32'(map_rows_q) > MAP_ROWS_MAX) ? RNW'(MAP_ROWS_MAX)
		: RNW'(map_rows_q);

	// cast setup
	logic [AAW+11:0] a_ext;
	logic [AAW-1:0]  a_red;
	logic [AAW-1:0]  r4;
	logic [AAW+30:0] zprod;
	assign a_ext = {{AAW{1'b0}}, angle};
	assign a_red = a_ext[AAW-1:0];
	assign r4 = {a_red[AAW-3:0], 2'b00};
	assign zprod = (AAW+31)'(r4) * (AAW+31)'(grwc_pkg::HALF_PI_Q30);

	logic [18:0] px_q, py_q;
	logic [1:0]  quad_q;
	logic        rzero_q;
	logic signed [31:0] x_q, y_q;
	logic signed [32:0] z_q;

	// rotation step
	logic [4:0] it;
	logic signed [31:0] dx, dy;
	logic signed [32:0] at;
	assign it = idx[4:0];
	assign dx = y_q >>> it;
	assign dy = x_q >>> it;
	assign at = $signed({1'b0, grwc_pkg::atan_q30(it)});

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			px_q <= pos_x;
			py_q <= pos_y;
			quad_q <= a_red[AAW-1 -: 2];
			rzero_q <= (a_red[AAW-3:0] == '0);
			x_q <= 32'sd536870912;
			y_q <= '0;
			z_q <= $signed({2'b00, zprod[AAW+30:AAW]});
		end else if (cmd.rot) begin
			if (!z_q[32]) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + at;
			end
		end
	end

	// quadrant rotation
	logic signed [31:0] cs, sn;
	always_comb begin
		case (quad_q)
			2'd0: begin cs = x_q; sn = y_q; end
			2'd1: begin cs = -y_q; sn = x_q; end
			2'd2: begin cs = -x_q; sn = -y_q; end
			default: begin cs = y_q; sn = -x_q; end
		endcase
	end

	// slope dividers: lane 0 cot (horizontal pass), lane 1 tan (vertical pass)
	logic [DB-1:0] dq_q [2];
	logic [31:0]   rem_q [2];
	logic [30:0]   den_q [2];
	logic          rsgn_q, hpar_q, vpar_q;
	logic [31:0]   rsh [2];
	logic          qbit [2];

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			rsh[l] = {rem_q[l][30:0], dq_q[l][DB-1]};
			qbit[l] = (rsh[l] >= {1'b0, den_q[l]});
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.quad) begin
			dq_q[0] <= {mag31(cs), 16'd0};
			den_q[0] <= mag31(sn);
			dq_q[1] <= {mag31(sn), 16'd0};
			den_q[1] <= mag31(cs);
			rem_q[0] <= '0;
			rem_q[1] <= '0;
			rsgn_q <= cs[31] ^ sn[31];
			hpar_q <= (((quad_q == 2'd0) || (quad_q == 2'd2)) && rzero_q) || (sn == '0);
			vpar_q <= (((quad_q == 2'd1) || (quad_q == 2'd3)) && rzero_q) || (cs == '0);
		end else if (cmd.div) begin
			for (int l = 0; l < 2; l++) begin
				rem_q[l] <= qbit[l] ? (rsh[l] - {1'b0, den_q[l]}) : rsh[l];
				dq_q[l] <= {dq_q[l][DB-2:0], qbit[l]};
			end
		end
	end

	// per-pass selection
	logic [DB-1:0] qsel;
	logic [36:0]   rmag;
	logic signed [37:0] rat;
	logic [18:0]   p0, q0;
	logic          neg, par;

	always_comb begin
		qsel = cmd.pass ? dq_q[1] : dq_q[0];
		rmag = (qsel > DB'(grwc_pkg::RATIO_CLAMP)) ? grwc_pkg::RATIO_CLAMP : qsel[36:0];
		rat = rsgn_q ? -$signed({1'b0, rmag}) : $signed({1'b0, rmag});
		p0 = cmd.pass ? px_q : py_q;
		q0 = cmd.pass ? py_q : px_q;
		neg = cmd.pass ? ((quad_q == 2'd1) || (quad_q == 2'd2)) : quad_q[1];
		par = cmd.pass ? vpar_q : hpar_q;
	end

	// stepper
	logic signed [39:0] rp_q, rq_q, sq_q;
	logic signed [15:0] delta_q;
	logic signed [53:0] acc_q;
	logic               neg_q;

	logic signed [39:0] base, rp_new, dfull;
	logic signed [15:0] delta;
	logic signed [19:0] lo_s;
	logic signed [35:0] plo;
	logic signed [18:0] hi_s;
	logic signed [34:0] phi;
	logic signed [53:0] full;
	logic [39:0]        sqm;

	always_comb begin
		base = $signed({21'd0, p0[18:14], 14'd0});
		rp_new = neg ? (base - 40'sd1) : (base + 40'sd16384);
		dfull = rp_new - $signed({21'd0, p0});
		delta = dfull[15:0];
		lo_s = $signed({1'b0, rat[18:0]});
		plo = delta * lo_s;
		hi_s = rat[37:19];
		phi = delta_q * hi_s;
		full = acc_q + ($signed({{19{phi[34]}}, phi}) <<< 19);
		sqm = {13'd0, rmag[36:10]} << 8;
	end

	// map lookup
	logic signed [39:0] lx, ly;
	logic [25:0] lcx, lcy;
	logic [31:0] lin;
	logic        off_d, off_q, rd_q;
	assign lx = cmd.pass ? rp_q : rq_q;
	assign ly = cmd.pass ? rq_q : rp_q;
	assign lcx = lx[39:14];
	assign lcy = ly[39:14];
	assign off_d = lx[39] || ly[39] || (lcx >= 26'(cols_lim)) || (lcy >= 26'(rows_lim));
	assign lin = 32'(lcy) * 32'(MAP_COLS_MAX) + 32'(lcx);

	logic [31:0] wlin;
	logic        w_inb;
	assign wlin = 32'(cell_row) * 32'(MAP_COLS_MAX) + 32'(cell_col);
	assign w_inb = (32'(cell_col) < MAP_COLS_MAX) && (32'(cell_row) < MAP_ROWS_MAX);

	logic mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			mem_q[idx[AW-1:0]] <= 1'b0;
		end else if (cmd.wr && w_inb) begin
			mem_q[wlin[AW-1:0]] <= wall_bit;
		end
		if (cmd.look) begin
			rd_q <= mem_q[lin[AW-1:0]];
		end
	end

	// step check
	logic wall, fin;
	logic signed [39:0] nrp, nrq;
	assign wall = !off_q && rd_q;
	assign fin = off_q || wall || cmd.last;
	assign nrp = rp_q + (neg_q ? -40'sd16384 : 40'sd16384);
	assign nrq = rq_q + sq_q;

	assign sts.par = par;
	assign sts.fin = fin;

	logic [23:0] res_x_q [2];
	logic [23:0] res_y_q [2];
	logic [1:0]  res_st_q [2];

	always_ff @(posedge clk) begin
		if (cmd.pset) begin
			rp_q <= rp_new;
			delta_q <= delta;
			acc_q <= {{18{plo[35]}}, plo};
			neg_q <= neg;
			sq_q <= (neg ^ rsgn_q) ? -$signed(sqm) : $signed(sqm);
			if (par) begin
				res_x_q[cmd.pass] <= {5'd0, px_q};
				res_y_q[cmd.pass] <= {5'd0, py_q};
				res_st_q[cmd.pass] <= grwc_pkg::ST_PAR;
			end
		end
		if (cmd.pmul) begin
			rq_q <= $signed({21'd0, q0}) + $signed({{2{full[53]}}, full[53:16]});
		end
		if (cmd.look) begin
			off_q <= off_d;
		end
		if (cmd.check) begin
			if (off_q) begin
				res_x_q[cmd.pass] <= {5'd0, px_q};
				res_y_q[cmd.pass] <= {5'd0, py_q};
				res_st_q[cmd.pass] <= grwc_pkg::ST_OFF;
			end else if (wall) begin
				res_x_q[cmd.pass] <= sat24(cmd.pass ? rp_q : rq_q);
				res_y_q[cmd.pass] <= sat24(cmd.pass ? rq_q : rp_q);
				res_st_q[cmd.pass] <= grwc_pkg::ST_HIT;
			end else if (cmd.last) begin
				res_x_q[cmd.pass] <= sat24(cmd.pass ? nrp : nrq);
				res_y_q[cmd.pass] <= sat24(cmd.pass ? nrq : nrp);
				res_st_q[cmd.pass] <= grwc_pkg::ST_LIMIT;
			end
			if (!fin) begin
				rp_q <= nrp;
				rq_q <= nrq;
			end
		end
	end

	// output register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			horiz_x <= res_x_q[0];
			horiz_y <= res_y_q[0];
			horiz_status <= res_st_q[0];
			vert_x <= res_x_q[1];
			vert_y <= res_y_q[1];
			vert_status <= res_st_q[1];
		end
	end

endmodule

// ===== hw/rtl/grid_ray_wall_caster_unit.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// grid_ray_wall_caster_unit
// casts a ray through a wall bitmap of 64-pixel cells, two grid passes
// ---------------------------------------------------------------------------
//  channel  handshake             payload
//  in       in_valid / in_ready   op, cell_col, cell_row, wall_bit, pos_x, pos_y, angle
//  out      out_valid / out_ready horiz_x/y/status, vert_x/y/status
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
//  a cast loads its inputs, rotates, fixes the quadrant and divides, then per
//  pass takes a parallel exit or a setup, a multiply and a look and check per
//  grid step, then hands off; the shared rotation unit and the bit-serial
//  dividers take most of a cast, each grid step costs one map read
//  after reset the map is cleared one cell a cycle (MAP_ROWS_MAX*MAP_COLS_MAX
//  cells, 1024 by default) with in_ready low; cfg beats are always taken
//  a finished result waits in the output register while new beats are taken
// ---------------------------------------------------------------------------
module grid_ray_wall_caster_unit #(
	parameter int MAP_COLS_MAX = 32,
	parameter int MAP_ROWS_MAX = 32,
	parameter int MAX_STEPS    = 8,
	parameter int ANGLE_STEPS  = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	// input beats
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               op,
	input  logic [4:0]         cell_col,
	input  logic [4:0]         cell_row,
	input  logic               wall_bit,
	input  logic [18:0]        pos_x,
	input  logic [18:0]        pos_y,
	input  logic [11:0]        angle,
	// result beats
	output logic               out_valid,
	input  logic               out_ready,
	output logic signed [23:0] horiz_x,
	output logic signed [23:0] horiz_y,
	output logic [1:0]         horiz_status,
	output logic signed [23:0] vert_x,
	output logic signed [23:0] vert_y,
	output logic [1:0]         vert_status,
	// register writes
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [5:0]         cfg_data
);

	// one counter serves map clear, rotation, divide and step count
	localparam int DEPTH = MAP_ROWS_MAX * MAP_COLS_MAX;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int SW    = $clog2(MAX_STEPS + 1);
	localparam int CW0   = (AW > 6) ? AW : 6;
	localparam int CW    = (CW0 > SW) ? CW0 : SW;

	grwc_pkg::cmd_t cmd;
	grwc_pkg::sts_t sts;
	logic [CW-1:0]  idx;

	// register writes never stall
	assign cfg_ready = 1'b1;

	grwc_ctrl #(
		.CW        (CW),
		.DEPTH     (DEPTH),
		.MAX_STEPS (MAX_STEPS)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd),
		.idx       (idx)
	);

	grwc_dp #(
		.CW           (CW),
		.MAP_COLS_MAX (MAP_COLS_MAX),
		.MAP_ROWS_MAX (MAP_ROWS_MAX),
		.ANGLE_STEPS  (ANGLE_STEPS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.idx          (idx),
		.sts          (sts),
		.cfg_valid    (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cell_col     (cell_col),
		.cell_row     (cell_row),
		.wall_bit     (wall_bit),
		.pos_x        (pos_x),
		.pos_y        (pos_y),
		.angle        (angle),
		.horiz_x      (horiz_x),
		.horiz_y      (horiz_y),
		.horiz_status (horiz_status),
		.vert_x       (vert_x),
		.vert_y       (vert_y),
		.vert_status  (vert_status)
	);

endmodule
